// ===== src/psg_pkg.sv =====
package psg_pkg;

  localparam int VOICES      = 3;
  localparam int REG_COUNT   = 16;
  localparam int REG_ADDR_W  = 4;
  localparam int DATA_W      = 8;
  localparam int TONE_W      = 12;
  localparam int NOISE_CNT_W = 6;
  localparam int NOISE_PER_W = 5;
  localparam int LFSR_W      = 17;
  localparam int ENV_CNT_W   = 17;
  localparam int ENV_PER_W   = 16;
  localparam int LEVEL_W     = 4;
  localparam int VOL_W       = 13;
  localparam int SAMPLE_W    = 14;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register map
  localparam logic [REG_ADDR_W-1:0] REG_TONE_A_FINE   = 4'd0;
  localparam logic [REG_ADDR_W-1:0] REG_TONE_A_COARSE = 4'd1;
  localparam logic [REG_ADDR_W-1:0] REG_TONE_B_FINE   = 4'd2;
  localparam logic [REG_ADDR_W-1:0] REG_TONE_B_COARSE = 4'd3;
  localparam logic [REG_ADDR_W-1:0] REG_TONE_C_FINE   = 4'd4;
  localparam logic [REG_ADDR_W-1:0] REG_TONE_C_COARSE = 4'd5;
  localparam logic [REG_ADDR_W-1:0] REG_NOISE_PER     = 4'd6;
  localparam logic [REG_ADDR_W-1:0] REG_MIXER         = 4'd7;
  localparam logic [REG_ADDR_W-1:0] REG_AMP_A         = 4'd8;
  localparam logic [REG_ADDR_W-1:0] REG_AMP_B         = 4'd9;
  localparam logic [REG_ADDR_W-1:0] REG_AMP_C         = 4'd10;
  localparam logic [REG_ADDR_W-1:0] REG_ENV_FINE      = 4'd11;
  localparam logic [REG_ADDR_W-1:0] REG_ENV_COARSE    = 4'd12;
  localparam logic [REG_ADDR_W-1:0] REG_ENV_SHAPE     = 4'd13;
  localparam logic [REG_ADDR_W-1:0] REG_PORT_A        = 4'd14;
  localparam logic [REG_ADDR_W-1:0] REG_PORT_B        = 4'd15;

  localparam logic RESULT_READ   = 1'b0;
  localparam logic RESULT_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    REQ_LATCH = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_TICK  = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t               op;
    logic [REG_ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]       data;
  } psg_cmd_t;

  typedef struct packed {
    logic                              kind;
    logic [DATA_W-1:0]                 read_data;
    logic [VOICES-1:0]                 on;
    logic [VOICES-1:0][LEVEL_W-1:0]    vol;
  } mix_req_t;

  function automatic logic [DATA_W-1:0] reg_mask(input logic [REG_ADDR_W-1:0] addr);
    logic [DATA_W-1:0] m;
    case (addr)
      REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE, REG_ENV_SHAPE: m = 8'h0f;
      REG_NOISE_PER, REG_AMP_A, REG_AMP_B, REG_AMP_C:                        m = 8'h1f;
      default:                                                                m = 8'hff;
    endcase
    return m;
  endfunction

  function automatic logic [VOL_W-1:0] vol_level(input logic [LEVEL_W-1:0] idx);
    logic [VOL_W-1:0] v;
    case (idx)
      4'd0:    v = 13'd0;
      4'd1:    v = 13'd40;
      4'd2:    v = 13'd60;
      4'd3:    v = 13'd86;
      4'd4:    v = 13'd124;
      4'd5:    v = 13'd186;
      4'd6:    v = 13'd264;
      4'd7:    v = 13'd440;
      4'd8:    v = 13'd518;
      4'd9:    v = 13'd840;
      4'd10:   v = 13'd1196;
      4'd11:   v = 13'd1526;
      4'd12:   v = 13'd2016;
      4'd13:   v = 13'd2602;
      4'd14:   v = 13'd3300;
      default: v = 13'd4096;
    endcase
    return v;
  endfunction

endpackage

// ===== src/psg_if.sv =====
interface psg_in_if;
  import psg_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              req_type;
  logic [REG_ADDR_W-1:0]   reg_select;
  logic [DATA_W-1:0]       write_data;

  modport source (output valid, output req_type, output reg_select, output write_data,
                  input ready);
  modport sink   (input valid, input req_type, input reg_select, input write_data,
                  output ready);
endinterface

interface psg_out_if;
  import psg_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  result_kind;
  logic [DATA_W-1:0]     read_data;
  logic [SAMPLE_W-1:0]   sample;

  modport source (output valid, output result_kind, output read_data, output sample,
                  input ready);
  modport sink   (input valid, input result_kind, input read_data, input sample,
                  output ready);
endinterface

// ===== src/psg_front.sv =====
module psg_front (
  input  logic               clk,
  input  logic               rst_n,
  psg_in_if.sink             in_ch,
  input  logic               q_full,
  output logic               q_push,
  output psg_pkg::psg_cmd_t  q_cmd
);
  import psg_pkg::*;

  logic [REG_ADDR_W-1:0] sel_r;
  logic                  accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // latch requests end here; everything else goes on with the resolved address
  always_comb begin
    q_push     = accept && (in_ch.req_type != REQ_LATCH);
    q_cmd.op   = req_kind_t'(in_ch.req_type);
    q_cmd.addr = sel_r;
    q_cmd.data = in_ch.write_data & reg_mask(sel_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= '0;
    end else if (accept && (in_ch.req_type == REQ_LATCH)) begin
      sel_r <= in_ch.reg_select;
    end
  end

endmodule

// ===== src/psg_queue.sv =====
module psg_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  psg_pkg::psg_cmd_t  push_cmd,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output psg_pkg::psg_cmd_t  pop_cmd
);
  import psg_pkg::*;

  psg_cmd_t           entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== src/psg_core.sv =====
module psg_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  psg_pkg::psg_cmd_t  q_cmd,
  output logic               q_pop,
  input  logic               mix_ready,
  output logic               mix_valid,
  output psg_pkg::mix_req_t  mix_req
);
  import psg_pkg::*;

  // envelope shape codes and bits
  localparam logic [3:0] ENV_SAW_DOWN     = 4'd8;
  localparam logic [3:0] ENV_TRI_DOWN     = 4'd10;
  localparam logic [3:0] ENV_DOWN_HOLD_HI = 4'd11;
  localparam logic [3:0] ENV_SAW_UP       = 4'd12;
  localparam logic [3:0] ENV_UP_HOLD_HI   = 4'd13;
  localparam logic [3:0] ENV_TRI_UP       = 4'd14;
  localparam int         ENV_HOLD_BIT     = 0;
  localparam int         ENV_ATT_BIT      = 2;
  localparam int         ENV_CONT_BIT     = 3;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
  localparam logic [LEVEL_W-1:0] STEP_LAST = '1;

  logic [DATA_W-1:0]       rf_r [REG_COUNT];
  logic [TONE_W-1:0]       tone_cnt_r [VOICES];
  logic [TONE_W-1:0]       tone_cnt_nxt [VOICES];
  logic [VOICES-1:0]       tone_ph_r, tone_ph_nxt;
  logic [NOISE_CNT_W-1:0]  noise_cnt_r, noise_cnt_nxt;
  logic [LFSR_W-1:0]       lfsr_r, lfsr_nxt;
  logic [ENV_CNT_W-1:0]    env_cnt_r, env_cnt_nxt;
  logic                    env_seg_r, env_seg_nxt;
  logic [LEVEL_W-1:0]      env_step_r, env_step_nxt;
  logic [LEVEL_W-1:0]      env_lvl_r, env_lvl_nxt;

  logic                    has_result, is_tick, is_write;
  logic [TONE_W-1:0]       tone_per [VOICES];
  logic [TONE_W-1:0]       tone_per_eff [VOICES];
  logic [TONE_W-1:0]       tone_inc [VOICES];
  logic [VOICES-1:0]       tone_wrap;
  logic [DATA_W-1:0]       amp [VOICES];
  logic [NOISE_PER_W-1:0]  noise_per;
  logic [NOISE_CNT_W-1:0]  noise_inc;
  logic                    noise_wrap;
  logic [ENV_CNT_W-1:0]    env_inc;
  logic                    env_wrap;
  logic [3:0]              shape, shape_w;
  logic [LEVEL_W-1:0]      lvl_stepped;
  logic                    seg_turn;
  logic [VOICES-1:0]       tone_dis, noise_dis, voice_on;

  function automatic logic [LEVEL_W-1:0] seg_start(input logic [3:0] shp, input logic seg);
    logic [LEVEL_W-1:0] l;
    if (seg) begin
      l = (shp == ENV_SAW_DOWN || shp == ENV_DOWN_HOLD_HI || shp == ENV_UP_HOLD_HI ||
           shp == ENV_TRI_UP) ? LEVEL_MAX : '0;
    end else begin
      l = shp[ENV_ATT_BIT] ? '0 : LEVEL_MAX;
    end
    return l;
  endfunction

  assign has_result = (q_cmd.op == REQ_READ) || (q_cmd.op == REQ_TICK);
  assign q_pop      = !q_empty && (!has_result || mix_ready);
  assign is_tick    = q_pop && (q_cmd.op == REQ_TICK);
  assign is_write   = q_pop && (q_cmd.op == REQ_WRITE);

  assign tone_per[0] = {rf_r[REG_TONE_A_COARSE][3:0], rf_r[REG_TONE_A_FINE]};
  assign tone_per[1] = {rf_r[REG_TONE_B_COARSE][3:0], rf_r[REG_TONE_B_FINE]};
  assign tone_per[2] = {rf_r[REG_TONE_C_COARSE][3:0], rf_r[REG_TONE_C_FINE]};
  assign amp[0]      = rf_r[REG_AMP_A];
  assign amp[1]      = rf_r[REG_AMP_B];
  assign amp[2]      = rf_r[REG_AMP_C];
  assign tone_dis    = rf_r[REG_MIXER][VOICES-1:0];
  assign noise_dis   = rf_r[REG_MIXER][2*VOICES-1:VOICES];
  assign noise_per   = rf_r[REG_NOISE_PER][NOISE_PER_W-1:0];
  assign shape       = rf_r[REG_ENV_SHAPE][3:0];
  assign shape_w     = q_cmd.data[3:0];

  // tone dividers
  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      tone_per_eff[i] = (tone_per[i] == '0) ? TONE_W'(1) : tone_per[i];
      tone_inc[i]     = tone_cnt_r[i] + TONE_W'(1);
      tone_wrap[i]    = (tone_inc[i] >= tone_per_eff[i]);
      tone_cnt_nxt[i] = tone_cnt_r[i];
      tone_ph_nxt[i]  = tone_ph_r[i];
      if (is_tick) begin
        tone_cnt_nxt[i] = tone_wrap[i] ? '0 : tone_inc[i];
        tone_ph_nxt[i]  = tone_ph_r[i] ^ tone_wrap[i];
      end
    end
  end

  // noise divider counts twice the period
  always_comb begin
    noise_inc     = noise_cnt_r + NOISE_CNT_W'(1);
    noise_wrap    = (noise_inc >= {((noise_per == '0) ? NOISE_PER_W'(1) : noise_per), 1'b0});
    noise_cnt_nxt = noise_cnt_r;
    lfsr_nxt      = lfsr_r;
    if (is_tick) begin
      noise_cnt_nxt = noise_wrap ? '0 : noise_inc;
      if (noise_wrap) begin
        lfsr_nxt = {lfsr_r[0] ^ lfsr_r[3], lfsr_r[LFSR_W-1:1]};
      end
    end
  end

  // envelope generator
  always_comb begin
    env_inc  = env_cnt_r + ENV_CNT_W'(1);
    env_wrap = (env_inc >= {rf_r[REG_ENV_COARSE], rf_r[REG_ENV_FINE], 1'b0});
    lvl_stepped = env_lvl_r;
    if (env_step_r != '0) begin
      if (env_seg_r) begin
        if (shape == ENV_TRI_DOWN || shape == ENV_SAW_UP) begin
          lvl_stepped = env_lvl_r + LEVEL_W'(1);
        end else if (shape == ENV_SAW_DOWN || shape == ENV_TRI_UP) begin
          lvl_stepped = env_lvl_r - LEVEL_W'(1);
        end
      end else if (shape[ENV_ATT_BIT]) begin
        lvl_stepped = env_lvl_r + LEVEL_W'(1);
      end else begin
        lvl_stepped = env_lvl_r - LEVEL_W'(1);
      end
    end
    seg_turn = shape[ENV_CONT_BIT] && !shape[ENV_HOLD_BIT];

    env_cnt_nxt  = env_cnt_r;
    env_seg_nxt  = env_seg_r;
    env_step_nxt = env_step_r;
    env_lvl_nxt  = env_lvl_r;
    if (is_tick) begin
      env_cnt_nxt = env_wrap ? '0 : env_inc;
      if (env_wrap) begin
        if (env_step_r == STEP_LAST) begin
          env_seg_nxt  = seg_turn ? !env_seg_r : 1'b1;
          env_step_nxt = '0;
          env_lvl_nxt  = seg_start(shape, env_seg_nxt);
        end else begin
          env_step_nxt = env_step_r + LEVEL_W'(1);
          env_lvl_nxt  = lvl_stepped;
        end
      end
    end else if (is_write && (q_cmd.addr == REG_ENV_SHAPE)) begin
      // restart the envelope from the new shape
      env_cnt_nxt  = '0;
      env_seg_nxt  = 1'b0;
      env_step_nxt = '0;
      env_lvl_nxt  = seg_start(shape_w, 1'b0);
    end
  end

  // per-voice gating on the post-tick state
  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      voice_on[i]   = (tone_dis[i] | tone_ph_nxt[i]) & (noise_dis[i] | lfsr_nxt[0]);
      mix_req.vol[i] = amp[i][LEVEL_W] ? env_lvl_nxt : amp[i][LEVEL_W-1:0];
    end
    mix_valid         = q_pop && has_result;
    mix_req.kind      = (q_cmd.op == REQ_TICK) ? RESULT_SAMPLE : RESULT_READ;
    mix_req.read_data = (q_cmd.op == REQ_READ) ? rf_r[q_cmd.addr] : '0;
    mix_req.on        = (q_cmd.op == REQ_TICK) ? voice_on : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        rf_r[i] <= '0;
      end
    end else if (is_write) begin
      rf_r[q_cmd.addr] <= q_cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        tone_cnt_r[i] <= '0;
      end
      tone_ph_r   <= '0;
      noise_cnt_r <= '0;
      lfsr_r      <= LFSR_W'(1);
      env_cnt_r   <= '0;
      env_seg_r   <= 1'b0;
      env_step_r  <= '0;
      env_lvl_r   <= '0;
    end else begin
      for (int i = 0; i < VOICES; i++) begin
        tone_cnt_r[i] <= tone_cnt_nxt[i];
      end
      tone_ph_r   <= tone_ph_nxt;
      noise_cnt_r <= noise_cnt_nxt;
      lfsr_r      <= lfsr_nxt;
      env_cnt_r   <= env_cnt_nxt;
      env_seg_r   <= env_seg_nxt;
      env_step_r  <= env_step_nxt;
      env_lvl_r   <= env_lvl_nxt;
    end
  end

`ifndef SYNTHESIS
  a_shape_write_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (is_write && (q_cmd.addr == REG_ENV_SHAPE)) |=>
      (env_cnt_r == '0) && (env_step_r == '0) && !env_seg_r)
    else $error("envelope not restarted after shape write");

  a_lfsr_alive: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != '0)
    else $error("noise LFSR locked at zero");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    is_write |-> !mix_valid)
    else $error("register write produced a result");
`endif

endmodule

// ===== src/psg_mix.sv =====
module psg_mix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               mix_valid,
  input  psg_pkg::mix_req_t  mix_req,
  output logic               mix_ready,
  psg_out_if.source          out_ch
);
  import psg_pkg::*;

  mix_req_t              mix_r;
  logic                  mix_v_r;
  logic                  out_v_r;
  logic                  out_kind_r;
  logic [DATA_W-1:0]     out_data_r;
  logic [SAMPLE_W-1:0]   out_sample_r;
  logic [SAMPLE_W-1:0]   sum_nxt;
  logic                  out_ld;

  assign out_ld    = mix_v_r && (!out_v_r || out_ch.ready);
  assign mix_ready = !mix_v_r || out_ld;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < VOICES; i++) begin
      if (mix_r.on[i]) begin
        sum_nxt = sum_nxt + SAMPLE_W'(vol_level(mix_r.vol[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mix_valid && mix_ready) begin
      mix_r <= mix_req;
    end
    if (out_ld) begin
      out_kind_r   <= mix_r.kind;
      out_data_r   <= mix_r.read_data;
      out_sample_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (mix_ready) begin
        mix_v_r <= mix_valid;
      end
      if (out_ld) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.read_data   = out_data_r;
  assign out_ch.sample      = out_sample_r;

`ifndef SYNTHESIS
  a_pending_held: assert property (@(posedge clk) disable iff (!rst_n)
    (mix_v_r && !out_ld) |=> (mix_v_r && $stable(mix_r)))
    else $error("pending request lost while output stalled");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ld |=> out_v_r)
    else $error("loaded result not presented");

  a_read_no_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_kind_r == RESULT_READ)) |-> (out_sample_r == '0))
    else $error("read result carries a sample");
`endif

endmodule

// ===== src/three_voice_psg_sound_generator.sv =====
// An accepted read or tick request passes the queue stage, execute into the mixer stage,
// table lookup and sum into the output register. Unless out_ch stalls, throughput is
// one request per cycle; the two-entry queue and the mixer stage absorb stalls.
// Latch requests end in the front; writes give no result and retire one per cycle in execute.
// Reset (rst_n low, synchronous): registers, dividers and envelope cleared, LFSR set to one,
// queue and output emptied; requests are taken on the first cycle after reset.
module three_voice_psg_sound_generator (
  input  logic        clk,
  input  logic        rst_n,
  psg_in_if.sink      in_ch,
  psg_out_if.source   out_ch
);
  import psg_pkg::*;

  logic      q_full, q_empty, q_push, q_pop;
  psg_cmd_t  push_cmd, pop_cmd;
  logic      mix_valid, mix_ready;
  mix_req_t  mix_req;

  psg_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  psg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_cmd  (pop_cmd)
  );

  psg_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .mix_ready (mix_ready),
    .mix_valid (mix_valid),
    .mix_req   (mix_req)
  );

  psg_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .mix_valid (mix_valid),
    .mix_req   (mix_req),
    .mix_ready (mix_ready),
    .out_ch    (out_ch)
  );

endmodule
